@@ rtl/core/stick_heading_relative_polar_defines.svh @@
// assertion macros shared by the checker
`ifndef STICK_HEADING_RELATIVE_POLAR_DEFINES_SVH
`define STICK_HEADING_RELATIVE_POLAR_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define SHRP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shrp: check failed");

// next-cycle implication, ignored while reset is high
`define SHRP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shrp: check failed");

// same-cycle implication that also holds around reset
`define SHRP_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("shrp: check failed");

`endif

@@ rtl/core/shrp_pkg.sv @@
package shrp_pkg;

  // port field widths
  localparam int STICK_W   = 16;
  localparam int HEADING_W = 32;
  localparam int OUT_W     = 15;

  // angle format
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int FINE_BITS       = 16;
  localparam int DROP            = FINE_BITS - ANGLE_FRAC_BITS;
  localparam int UNIT_FULL       = 360 << ANGLE_FRAC_BITS;
  localparam int UNIT_HALF       = 180 << ANGLE_FRAC_BITS;
  localparam int UNIT_QTR        = 90 << ANGLE_FRAC_BITS;
  localparam int UNIT_3QTR       = 270 << ANGLE_FRAC_BITS;
  localparam int UNIT_W          = $clog2(UNIT_FULL);

  // cordic
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int ATAN_W        = 22;
  localparam int CORDIC_USED   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int AXIS_W        = STICK_W + 1;
  localparam int CR_W          = AXIS_W + FINE_BITS + 3;
  localparam int Z_W           = ATAN_W + 2;
  localparam int FINE_W        = Z_W + 2;

  // magnitude
  localparam int R2_W       = 2 * STICK_W;
  localparam int ROOT_W     = R2_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SPEED_MAX  = 23171;

  localparam int BACK_DEPTH = (CORDIC_USED > SQRT_STEPS) ? CORDIC_USED : SQRT_STEPS;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // atan(2^-i) in degrees, scaled by 2^16
  localparam logic [ATAN_W-1:0] ATAN_DEG16 [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef enum logic [2:0] {
    CLS_GENERAL,
    CLS_ZERO,
    CLS_NORTH,
    CLS_EAST,
    CLS_SOUTH,
    CLS_WEST
  } shrp_cls_t;

  // one classified sample waiting for the back end
  typedef struct packed {
    shrp_cls_t                 cls;
    logic                      south;
    logic signed [AXIS_W-1:0]  north_c;
    logic signed [AXIS_W-1:0]  east_c;
    logic [R2_W-1:0]           r2;
    logic [UNIT_W-1:0]         robot;
  } shrp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } shrp_qstat_t;

endpackage

@@ rtl/core/shrp_in_if.sv @@
interface shrp_in_if;
  import shrp_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [STICK_W-1:0]   stick_x;
  logic signed [STICK_W-1:0]   stick_y;
  logic signed [HEADING_W-1:0] heading;

  modport source (output valid, output stick_x, output stick_y, output heading, input ready);
  modport sink (input valid, input stick_x, input stick_y, input heading, output ready);
endinterface

@@ rtl/core/shrp_out_if.sv @@
interface shrp_out_if;
  import shrp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] steer_dir;
  logic [OUT_W-1:0]        speed;

  modport source (output valid, output steer_dir, output speed, input ready);
  modport sink (input valid, input steer_dir, input speed, output ready);
endinterface

@@ rtl/core/shrp_front.sv @@
module shrp_front (
  input  logic                clk,
  input  logic                rst,
  shrp_in_if.sink             sample,
  input  shrp_pkg::shrp_qstat_t qstat,
  output logic                push,
  output shrp_pkg::shrp_job_t push_job
);
  import shrp_pkg::*;

  // heading mod UNIT_FULL by reciprocal multiply, estimate low by at most one
  localparam int RECIP_SHIFT = HEADING_W + $clog2(UNIT_FULL) - 1;
  localparam int Q_W         = 2 * HEADING_W - RECIP_SHIFT;
  localparam logic [HEADING_W-1:0] RECIP = HEADING_W'((64'd1 << RECIP_SHIFT) / UNIT_FULL);
  localparam logic [UNIT_W-1:0] M_C = UNIT_W'(UNIT_FULL);
  // the heading is offset by half the 32-bit range to make it unsigned
  localparam logic [UNIT_W-1:0] OFF_C =
    UNIT_W'((64'd1 << (HEADING_W - 1)) % UNIT_FULL);
  localparam logic [UNIT_W-1:0] OFF_COMP_C = UNIT_W'(UNIT_FULL - ((64'd1 << (HEADING_W - 1)) % UNIT_FULL));

  logic       fen;
  logic [3:0] v;

  // stage 0: captured word
  logic signed [STICK_W-1:0] s0_x, s0_y;
  logic [HEADING_W-1:0]      s0_h;

  // stage 1: classified, products
  shrp_cls_t                s1_cls;
  logic                     s1_south;
  logic signed [AXIS_W-1:0] s1_north, s1_east;
  logic [R2_W-1:0]          s1_xx, s1_yy;
  logic [HEADING_W-1:0]     s1_u;
  logic [Q_W-1:0]           s1_q;

  // stage 2: sum of squares, raw remainder
  shrp_cls_t                s2_cls;
  logic                     s2_south;
  logic signed [AXIS_W-1:0] s2_north, s2_east;
  logic [R2_W-1:0]          s2_r2;
  logic [UNIT_W:0]          s2_r;

  // stage 3
  shrp_job_t s3_job;

  logic signed [AXIS_W-1:0]   xe, ye;
  logic signed [2*AXIS_W-1:0] xsq, ysq;
  logic [HEADING_W-1:0]       hu;
  logic [2*HEADING_W-1:0]     prod;
  logic [Q_W+UNIT_W-1:0]      qm;
  logic [UNIT_W-1:0]          r1;
  shrp_cls_t                  cls;

  assign fen = !(v[3] && qstat.full);
  assign sample.ready = fen;
  assign push = v[3] && fen;
  assign push_job = s3_job;

  assign xe   = $signed({s0_x[STICK_W-1], s0_x});
  assign ye   = -$signed({s0_y[STICK_W-1], s0_y});
  assign xsq  = xe * xe;
  assign ysq  = ye * ye;
  assign hu   = {~s0_h[HEADING_W-1], s0_h[HEADING_W-2:0]};
  assign prod = hu * RECIP;
  assign qm   = s1_q * M_C;
  assign r1   = (s2_r >= {1'b0, M_C}) ? UNIT_W'(s2_r - {1'b0, M_C}) : s2_r[UNIT_W-1:0];

  always_comb begin
    if (xe == '0 && ye == '0) begin
      cls = CLS_ZERO;
    end else if (xe == '0) begin
      cls = (ye > 0) ? CLS_NORTH : CLS_SOUTH;
    end else if (ye == '0) begin
      cls = (xe > 0) ? CLS_EAST : CLS_WEST;
    end else begin
      cls = CLS_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (fen) begin
      v <= {v[2:0], sample.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      s0_x <= sample.stick_x;
      s0_y <= sample.stick_y;
      s0_h <= sample.heading;

      s1_cls   <= cls;
      s1_south <= ye[AXIS_W-1];
      s1_north <= ye[AXIS_W-1] ? -ye : ye;
      s1_east  <= ye[AXIS_W-1] ? -xe : xe;
      s1_xx    <= xsq[R2_W-1:0];
      s1_yy    <= ysq[R2_W-1:0];
      s1_u     <= hu;
      s1_q     <= prod[2*HEADING_W-1 -: Q_W];

      s2_cls   <= s1_cls;
      s2_south <= s1_south;
      s2_north <= s1_north;
      s2_east  <= s1_east;
      s2_r2    <= s1_xx + s1_yy;
      s2_r     <= (UNIT_W+1)'(s1_u - qm[HEADING_W-1:0]);

      s3_job.cls     <= s2_cls;
      s3_job.south   <= s2_south;
      s3_job.north_c <= s2_north;
      s3_job.east_c  <= s2_east;
      s3_job.r2      <= s2_r2;
      s3_job.robot   <= (r1 >= OFF_C) ? UNIT_W'(r1 - OFF_C) : UNIT_W'(r1 + OFF_COMP_C);
    end
  end

endmodule

@@ rtl/core/shrp_queue.sv @@
module shrp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  shrp_pkg::shrp_job_t   push_job,
  input  logic                  pop,
  output shrp_pkg::shrp_job_t   head,
  output shrp_pkg::shrp_qstat_t qstat
);
  import shrp_pkg::*;

  shrp_job_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/shrp_back.sv @@
module shrp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  shrp_pkg::shrp_job_t   head,
  input  shrp_pkg::shrp_qstat_t qstat,
  output logic                  pop,
  shrp_out_if.source            result
);
  import shrp_pkg::*;

  typedef struct packed {
    shrp_cls_t              cls;
    logic                   south;
    logic signed [CR_W-1:0] ca;
    logic signed [CR_W-1:0] cb;
    logic signed [Z_W-1:0]  z;
    logic [R2_W-1:0]        rad;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic [UNIT_W-1:0]      robot;
  } stage_t;

  localparam logic signed [FINE_W-1:0] FINE_FULL_C = FINE_W'(360 << FINE_BITS);
  localparam logic signed [FINE_W-1:0] FINE_HALF_C = FINE_W'(180 << FINE_BITS);
  localparam logic signed [FINE_W-1:0] FINE_ZERO_C = '0;
  localparam logic [FINE_W-1:0]        BIAS_C      = FINE_W'(1 << (DROP - 1));
  localparam logic [UNIT_W:0]          FULL_RND_C  = (UNIT_W+1)'(UNIT_FULL);
  localparam logic signed [UNIT_W:0]   FULL_S      = (UNIT_W+1)'(UNIT_FULL);
  localparam logic signed [UNIT_W:0]   HALF_S      = (UNIT_W+1)'(UNIT_HALF);
  localparam logic signed [UNIT_W:0]   NHALF_S     = -HALF_S;

  logic   badv;
  stage_t init;
  stage_t stage_q [BACK_DEPTH];
  logic [BACK_DEPTH-1:0] stage_v;

  logic              fin_v;
  logic [UNIT_W-1:0] fin_stick;
  logic [UNIT_W-1:0] fin_robot;
  logic [OUT_W-1:0]  fin_speed;

  logic [UNIT_W-1:0] fin_stick_d;
  logic [UNIT_W-1:0] fin_robot_d;
  logic [OUT_W-1:0]  fin_speed_d;

  logic signed [UNIT_W:0] diff;
  logic signed [UNIT_W:0] wrapped;

  assign badv = !result.valid || result.ready;
  assign pop  = badv && !qstat.empty;

  always_comb begin
    init.cls   = head.cls;
    init.south = head.south;
    init.ca    = $signed({{(CR_W-AXIS_W-FINE_BITS){head.north_c[AXIS_W-1]}},
                          head.north_c, {FINE_BITS{1'b0}}});
    init.cb    = $signed({{(CR_W-AXIS_W-FINE_BITS){head.east_c[AXIS_W-1]}},
                          head.east_c, {FINE_BITS{1'b0}}});
    init.z     = '0;
    init.rad   = head.r2;
    init.rem   = '0;
    init.root  = '0;
    init.robot = head.robot;
  end

  // one cordic rotation and one root digit per stage
  for (genvar k = 0; k < BACK_DEPTH; k++) begin : g_stage
    stage_t cur, rot, nxt;

    if (k == 0) begin : g_first
      assign cur = init;
    end else begin : g_chain
      assign cur = stage_q[k-1];
    end

    if (k < CORDIC_USED) begin : g_rot
      always_comb begin
        rot = cur;
        if ($signed(cur.cb) > 0) begin
          rot.ca = $signed(cur.ca) + ($signed(cur.cb) >>> k);
          rot.cb = $signed(cur.cb) - ($signed(cur.ca) >>> k);
          rot.z  = $signed(cur.z) + $signed({2'b00, ATAN_DEG16[k]});
        end else begin
          rot.ca = $signed(cur.ca) - ($signed(cur.cb) >>> k);
          rot.cb = $signed(cur.cb) + ($signed(cur.ca) >>> k);
          rot.z  = $signed(cur.z) - $signed({2'b00, ATAN_DEG16[k]});
        end
      end
    end else begin : g_rot_idle
      assign rot = cur;
    end

    if (k < SQRT_STEPS) begin : g_root
      always_comb begin
        logic [REM_W+1:0] rsh;
        logic [REM_W+1:0] trial;
        nxt   = rot;
        rsh   = {rot.rem, rot.rad[R2_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W){1'b0}}, rot.root, 2'b01};
        nxt.rad = {rot.rad[R2_W-3:0], 2'b00};
        if (rsh >= trial) begin
          nxt.rem  = REM_W'(rsh - trial);
          nxt.root = {rot.root[ROOT_W-2:0], 1'b1};
        end else begin
          nxt.rem  = REM_W'(rsh);
          nxt.root = {rot.root[ROOT_W-2:0], 1'b0};
        end
      end
    end else begin : g_root_idle
      assign nxt = rot;
    end

    always_ff @(posedge clk) begin
      if (badv) begin
        stage_q[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v      <= '0;
      fin_v        <= 1'b0;
      result.valid <= 1'b0;
    end else if (badv) begin
      stage_v      <= {stage_v[BACK_DEPTH-2:0], pop};
      fin_v        <= stage_v[BACK_DEPTH-1];
      result.valid <= fin_v;
    end
  end

  // angle rounding, axis overrides, speed rounding and cap
  always_comb begin
    stage_t                   last;
    logic signed [FINE_W-1:0] base;
    logic signed [FINE_W-1:0] fine_s;
    logic [FINE_W-1:0]        fine_b;
    logic [UNIT_W:0]          rnd;
    logic [UNIT_W-1:0]        gen;
    logic [ROOT_W:0]          sp;
    last   = stage_q[BACK_DEPTH-1];
    base   = last.south ? FINE_HALF_C : FINE_ZERO_C;
    fine_s = base + $signed({{(FINE_W-Z_W){last.z[Z_W-1]}}, last.z});
    if (fine_s[FINE_W-1]) begin
      fine_s = fine_s + FINE_FULL_C;
    end
    fine_b = fine_s + BIAS_C;
    rnd    = (UNIT_W+1)'(fine_b >> DROP);
    gen    = (rnd >= FULL_RND_C) ? '0 : rnd[UNIT_W-1:0];
    case (last.cls)
      CLS_ZERO:  fin_stick_d = '0;
      CLS_NORTH: fin_stick_d = '0;
      CLS_EAST:  fin_stick_d = UNIT_W'(UNIT_QTR);
      CLS_SOUTH: fin_stick_d = UNIT_W'(UNIT_HALF);
      CLS_WEST:  fin_stick_d = UNIT_W'(UNIT_3QTR);
      default:   fin_stick_d = gen;
    endcase
    sp = {1'b0, last.root} + (ROOT_W+1)'(last.rem > REM_W'(last.root));
    fin_speed_d = (sp > (ROOT_W+1)'(SPEED_MAX)) ? OUT_W'(SPEED_MAX) : OUT_W'(sp);
    fin_robot_d = last.robot;
  end

  // heading minus stick, wrapped to a half turn either way
  always_comb begin
    diff = $signed({1'b0, fin_robot}) - $signed({1'b0, fin_stick});
    if (diff > HALF_S) begin
      wrapped = diff - FULL_S;
    end else if (diff < NHALF_S) begin
      wrapped = diff + FULL_S;
    end else begin
      wrapped = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      fin_stick        <= fin_stick_d;
      fin_robot        <= fin_robot_d;
      fin_speed        <= fin_speed_d;
      result.steer_dir <= OUT_W'(wrapped);
      result.speed     <= fin_speed;
    end
  end

endmodule

@@ rtl/core/stick_heading_relative_polar.sv @@
// stick_heading_relative_polar: joystick sample plus robot heading in, heading-relative
// wheel direction and stick speed out, one result word per input word.
// channels: sample (stick_x, stick_y, heading) and result (steer_dir, speed),
// both valid/ready; a word moves on a clock edge with valid and ready high.
// angles are in 1/64 degree; speed is the stick magnitude in Q1.14, capped at 23171.
// BACK_DEPTH is the longer of the cordic chain and the 16-step root chain.
// throughput: one word per cycle while result is not stalled; every cordic rotation
// and root digit has its own stage, so each unit can take a new word each cycle.
// the front end takes a word every cycle while the 4-entry queue has room; the back
// end pops the queue whenever its output register is empty or being taken.
// reset (rst, synchronous) clears all valid bits and empties the queue; no payload
// register is cleared.
// when result is stalled the back end freezes with its word held on the port, the
// queue fills, then the front pipeline fills and sample.ready drops.
module stick_heading_relative_polar (
  input  logic       clk,
  input  logic       rst,
  shrp_in_if.sink    sample,
  shrp_out_if.source result
);
  import shrp_pkg::*;

  shrp_qstat_t qstat;
  shrp_job_t   push_job;
  shrp_job_t   head;
  logic        push;
  logic        pop;

  // classify the sample, reduce the heading, square the axes
  shrp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  // lets the front keep taking words while the result side stalls
  shrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // cordic angle, square root, rounding and wrap
  shrp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ rtl/core/shrp_chk.sv @@
`include "stick_heading_relative_polar_defines.svh"

module shrp_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [shrp_pkg::OUT_W-1:0] steer_dir,
  input logic [shrp_pkg::OUT_W-1:0]    speed
);
  import shrp_pkg::*;

  // words accepted but not yet delivered
  logic [7:0] pending;
  logic       dir_ok;

  assign dir_ok = (steer_dir <= UNIT_HALF) && (steer_dir >= -UNIT_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  `SHRP_ASSERT_IMP(a_speed_cap, clk, rst, out_valid, speed <= OUT_W'(SPEED_MAX))
  `SHRP_ASSERT_IMP(a_dir_range, clk, rst, out_valid, dir_ok)
  `SHRP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `SHRP_ASSERT_IMP(a_no_orphan, clk, rst, out_valid, pending != '0)
  `SHRP_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst), !out_valid)

endmodule

bind stick_heading_relative_polar shrp_chk u_shrp_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .steer_dir (result.steer_dir),
  .speed     (result.speed)
);
